[hw/rtl/nvp_pkg.sv]
package nvp_pkg;

    localparam int MESH_ID_BITS   = 8;
    localparam int VERTEX_ID_BITS = 24;

    // Accumulator holds four 49-bit products without overflow.
    localparam int ACC_W  = 51;
    localparam int PROD_W = 49;
    localparam int REM_W  = ACC_W + 1;
    localparam int QUO_W  = 15;

    localparam logic [4:0] TERM_W_LAST    = 5'd3;
    localparam logic [4:0] TERM_Z_LAST    = 5'd15;
    localparam logic [4:0] TERM_DOT_FIRST = 5'd16;
    localparam logic [4:0] TERM_DOT_LAST  = 5'd18;
    localparam logic [4:0] TERM_DSQ_FIRST = 5'd19;
    localparam logic [4:0] TERM_DSQ_LAST  = 5'd20;
    localparam logic [3:0] DIV_LAST_STEP  = 4'd14;
    localparam logic [1:0] COORD_LAST     = 2'd2;

    localparam logic [31:0] EPS_SQ_Q28 = 32'd167772;
    localparam logic signed [ACC_W-1:0] NEG_TENTH_Q28 = -51'sd26843546;

    typedef enum logic [2:0] {
        CFG_ROW0   = 3'd0,
        CFG_ROW1   = 3'd1,
        CFG_ROW2   = 3'd2,
        CFG_ROW3   = 3'd3,
        CFG_CAMERA = 3'd4,
        CFG_CLICK  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0]           pos_x;
        logic signed [31:0]           pos_y;
        logic signed [31:0]           pos_z;
        logic signed [15:0]           norm_x;
        logic signed [15:0]           norm_y;
        logic signed [15:0]           norm_z;
        logic [MESH_ID_BITS-1:0]      mesh_id;
        logic [VERTEX_ID_BITS-1:0]    vertex_id;
        logic                         last_vertex;
    } t_in_item;

    typedef struct packed {
        logic                         hit;
        logic [MESH_ID_BITS-1:0]      hit_mesh;
        logic [VERTEX_ID_BITS-1:0]    hit_vertex;
        logic [31:0]                  hit_distance_sq;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_ACC,
        OP_SAVE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_UPDATE,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        G_W,
        G_X,
        G_Y,
        G_Z,
        G_DOT,
        G_DSQ
    } t_group;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_SAVE,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_END,
        S_DECIDE,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [4:0] term;
        logic [1:0] coord;
    } t_cmd;

    typedef struct packed {
        logic w_pos;
        logic last;
        logic out_free;
    } t_status;

    function automatic t_group term_group(input logic [4:0] term);
        t_group g;
        if (term <= TERM_W_LAST) begin
            g = G_W;
        end else if (term <= 5'd7) begin
            g = G_X;
        end else if (term <= 5'd11) begin
            g = G_Y;
        end else if (term <= TERM_Z_LAST) begin
            g = G_Z;
        end else if (term <= TERM_DOT_LAST) begin
            g = G_DOT;
        end else begin
            g = G_DSQ;
        end
        return g;
    endfunction

    function automatic logic term_first(input logic [4:0] term);
        return (term <= TERM_Z_LAST && term[1:0] == 2'd0) ||
               term == TERM_DOT_FIRST || term == TERM_DSQ_FIRST;
    endfunction

    function automatic logic term_final(input logic [4:0] term);
        return (term <= TERM_Z_LAST && term[1:0] == 2'd3) ||
               term == TERM_DOT_LAST || term == TERM_DSQ_LAST;
    endfunction

endpackage

[hw/rtl/nvp_ctrl.sv]
module nvp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  nvp_pkg::t_status i_status,
    output nvp_pkg::t_cmd    o_cmd
);
    import nvp_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_term, n_term;
    logic [3:0] r_step, n_step;
    logic [1:0] r_coord, n_coord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_term  <= '0;
            r_step  <= '0;
            r_coord <= '0;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
            r_step  <= n_step;
            r_coord <= n_coord;
        end
    end

    // Next state and sequence counters.
    always_comb begin
        n_state = r_state;
        n_term  = r_term;
        n_step  = r_step;
        n_coord = r_coord;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_term  = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                if (term_final(r_term)) begin
                    n_state = S_SAVE;
                end else begin
                    n_term  = r_term + 5'd1;
                    n_state = S_MUL;
                end
            end
            S_SAVE: begin
                if (r_term == TERM_W_LAST) begin
                    if (i_status.w_pos) begin
                        n_term  = r_term + 5'd1;
                        n_state = S_MUL;
                    end else begin
                        n_state = i_status.last ? S_FINISH : S_IDLE;
                    end
                end else if (r_term == TERM_Z_LAST) begin
                    n_coord = '0;
                    n_state = S_DIV_INIT;
                end else if (r_term == TERM_DSQ_LAST) begin
                    n_state = S_DECIDE;
                end else begin
                    n_term  = r_term + 5'd1;
                    n_state = S_MUL;
                end
            end
            S_DIV_INIT: begin
                n_step  = '0;
                n_state = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                n_step = r_step + 4'd1;
                if (r_step == DIV_LAST_STEP) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                if (r_coord == COORD_LAST) begin
                    n_term  = TERM_DOT_FIRST;
                    n_state = S_MUL;
                end else begin
                    n_coord = r_coord + 2'd1;
                    n_state = S_DIV_INIT;
                end
            end
            S_DECIDE: begin
                n_state = i_status.last ? S_FINISH : S_IDLE;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.op    = OP_NONE;
        o_cmd.term  = r_term;
        o_cmd.coord = r_coord;
        o_in_stall  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                end
            end
            S_MUL:      o_cmd.op = OP_MUL;
            S_ACC:      o_cmd.op = OP_ACC;
            S_SAVE:     o_cmd.op = OP_SAVE;
            S_DIV_INIT: o_cmd.op = OP_DIV_INIT;
            S_DIV_STEP: o_cmd.op = OP_DIV_STEP;
            S_DIV_END:  o_cmd.op = OP_DIV_END;
            S_DECIDE:   o_cmd.op = OP_UPDATE;
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_FINISH;
                end
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

[hw/rtl/nvp_dp.sv]
module nvp_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  nvp_pkg::t_in_item i_in_data,
    input  nvp_pkg::t_cmd     i_cmd,
    output nvp_pkg::t_status  o_status,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output nvp_pkg::t_out_item o_out_data
);
    import nvp_pkg::*;

    logic [63:0] r_row0, r_row1, r_row2, r_row3;
    logic [47:0] r_camera, r_click;

    t_in_item r_item;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_w, r_cx, r_cy, r_cz, r_dot, r_dsq;

    logic [REM_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    logic             r_neg, r_sat;
    logic signed [15:0] r_xn, r_yn, r_zn;

    logic        r_best_valid;
    logic [31:0] r_best_dist;
    logic [MESH_ID_BITS-1:0]   r_best_mesh;
    logic [VERTEX_ID_BITS-1:0] r_best_vert;

    logic      r_out_valid;
    t_out_item r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0   <= 64'h0000_0000_0000_1000;
            r_row1   <= 64'h0000_0000_1000_0000;
            r_row2   <= 64'h0000_1000_0000_0000;
            r_row3   <= 64'h1000_0000_0000_0000;
            r_camera <= 48'hC000_0000_0000;
            r_click  <= 48'hFFFF_0000_0000;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROW0:   r_row0   <= i_cfg_data;
                CFG_ROW1:   r_row1   <= i_cfg_data;
                CFG_ROW2:   r_row2   <= i_cfg_data;
                CFG_ROW3:   r_row3   <= i_cfg_data;
                CFG_CAMERA: r_camera <= i_cfg_data[47:0];
                CFG_CLICK:  r_click  <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    t_group             grp;
    logic [63:0]        row;
    logic [1:0]         k;
    logic signed [16:0] op_a;
    logic signed [31:0] op_b;
    logic signed [16:0] dx, dy;
    logic signed [15:0] norm_k, cam_k;
    logic [1:0]         dk;

    assign grp = term_group(i_cmd.term);
    assign k   = i_cmd.term[1:0];
    assign dx  = 17'(r_xn) - 17'(signed'(r_click[15:0]));
    assign dy  = 17'(r_yn) - 17'(signed'(r_click[31:16]));
    assign dk  = 2'(i_cmd.term - TERM_DOT_FIRST);

    always_comb begin
        case (grp)
            G_W:     row = r_row3;
            G_X:     row = r_row0;
            G_Y:     row = r_row1;
            default: row = r_row2;
        endcase
        case (dk)
            2'd0:    begin norm_k = r_item.norm_x; cam_k = signed'(r_camera[15:0]);  end
            2'd1:    begin norm_k = r_item.norm_y; cam_k = signed'(r_camera[31:16]); end
            default: begin norm_k = r_item.norm_z; cam_k = signed'(r_camera[47:32]); end
        endcase
        op_a = 17'(signed'(row[16*k +: 16]));
        case (k)
            2'd0:    op_b = r_item.pos_x;
            2'd1:    op_b = r_item.pos_y;
            2'd2:    op_b = r_item.pos_z;
            default: op_b = 32'sd65536;
        endcase
        if (grp == G_DOT) begin
            op_a = 17'(cam_k);
            op_b = 32'(norm_k);
        end else if (grp == G_DSQ) begin
            op_a = (i_cmd.term == TERM_DSQ_FIRST) ? dx : dy;
            op_b = 32'(op_a);
        end
    end

    // Division of a clip coordinate by w.
    logic signed [ACC_W-1:0] clip;
    logic [ACC_W-1:0]        mag;
    logic                    ge;
    logic [REM_W-1:0]        rem_next;
    logic signed [15:0]      ndc;

    always_comb begin
        case (i_cmd.coord)
            2'd0:    clip = r_cx;
            2'd1:    clip = r_cy;
            default: clip = r_cz;
        endcase
        mag      = clip[ACC_W-1] ? ACC_W'(-clip) : ACC_W'(clip);
        ge       = r_rem >= REM_W'(unsigned'(r_w));
        rem_next = ge ? (r_rem - REM_W'(unsigned'(r_w))) : r_rem;
        if (r_sat) begin
            ndc = r_neg ? 16'sh8000 : 16'sh7FFF;
        end else begin
            ndc = r_neg ? -signed'({1'b0, r_quo}) : signed'({1'b0, r_quo});
        end
    end

    // Tests on the finished vertex.
    logic [17:0] zsum;
    logic signed [17:0] depth;
    logic faces, near, visible;

    assign zsum    = 18'(r_zn) + 18'd16384;
    assign depth   = signed'({zsum[16:0], 1'b0});
    assign faces   = r_dot <= NEG_TENTH_Q28;
    assign near    = r_dsq <= signed'(ACC_W'(EPS_SQ_Q28)) &&
                     r_dsq <= signed'(ACC_W'(r_best_dist));
    assign visible = depth <= signed'({2'b00, r_click[47:32]});

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: r_item <= i_in_data;
            OP_MUL:  r_prod <= op_a * op_b;
            OP_ACC: begin
                if (term_first(i_cmd.term)) begin
                    r_acc <= ACC_W'(r_prod);
                end else begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
            OP_SAVE: begin
                case (grp)
                    G_W:     r_w   <= r_acc;
                    G_X:     r_cx  <= r_acc;
                    G_Y:     r_cy  <= r_acc;
                    G_Z:     r_cz  <= r_acc;
                    G_DOT:   r_dot <= r_acc;
                    default: r_dsq <= r_acc;
                endcase
            end
            OP_DIV_INIT: begin
                r_rem <= REM_W'(mag);
                r_neg <= clip[ACC_W-1];
                r_sat <= REM_W'(mag) >= {unsigned'(r_w), 1'b0};
                r_quo <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= {rem_next[REM_W-2:0], 1'b0};
                r_quo <= {r_quo[QUO_W-2:0], ge};
            end
            OP_DIV_END: begin
                case (i_cmd.coord)
                    2'd0:    r_xn <= ndc;
                    2'd1:    r_yn <= ndc;
                    default: r_zn <= ndc;
                endcase
            end
            default: ;
        endcase
    end

    // Running best and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
            r_best_dist  <= EPS_SQ_Q28;
            r_best_mesh  <= '0;
            r_best_vert  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op == OP_UPDATE && faces && near && visible) begin
                r_best_valid <= 1'b1;
                r_best_dist  <= r_dsq[31:0];
                r_best_mesh  <= r_item.mesh_id;
                r_best_vert  <= r_item.vertex_id;
            end
            if (i_cmd.op == OP_FINISH) begin
                r_out_valid  <= 1'b1;
                r_best_valid <= 1'b0;
                r_best_dist  <= EPS_SQ_Q28;
                r_best_mesh  <= '0;
                r_best_vert  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FINISH) begin
            if (r_best_valid) begin
                r_out.hit             <= 1'b1;
                r_out.hit_mesh        <= r_best_mesh;
                r_out.hit_vertex      <= r_best_vert;
                r_out.hit_distance_sq <= r_best_dist;
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_status.w_pos    = r_acc > 0;
    assign o_status.last     = r_item.last_vertex;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

[hw/rtl/nearest_vertex_pick_top.sv]
// Nearest-vertex picker: vertices stream in one transfer at a time; each is
// transformed by the configured 4x4 Q4.12 matrix, divided by w into Q2.14
// NDC, and kept as the running best if it faces the camera, lies within
// 0.025 NDC of the click point and no farther than the best so far (ties go
// to the later vertex), and is not behind the depth-buffer value. A vertex
// with non-positive w is a miss. The transfer flagged last_vertex produces
// one result transfer (hit, mesh, vertex, squared distance; all zero on no
// hit) and clears the best. A new vertex is taken only after the last one is
// done, which is sooner when w is non-positive; the final vertex also loads
// the result register. The processing time is set by the single shared 17x32
// multiplier (21 products, each a multiply and an accumulate step) and the
// restoring divider, which produces one quotient bit per cycle for 15 bits per
// coordinate. Configuration writes are always taken and must only be issued
// while no vertex is in flight.
module nearest_vertex_pick_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  nvp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output nvp_pkg::t_out_item o_out_data
);
    import nvp_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The register file never back-pressures a write.
    assign o_cfg_ready = 1'b1;

    nvp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    nvp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[tb/sv/nearest_vertex_pick_top_tb.sv]
module nearest_vertex_pick_top_tb;
    import nvp_pkg::*;

    // Tracks the running nearest vertex the way the block should, and keeps
    // the picks that are still owed on the result channel, oldest first.
    class pick_tracker;
        logic [63:0] rows [4];
        logic [47:0] camera;
        logic [47:0] click;
        logic        have_best;
        logic [31:0] best_dsq;
        logic [7:0]  best_mesh;
        logic [23:0] best_vertex;
        t_out_item   pending_picks [$];
        int          mismatches;

        function new();
            rows[0] = 64'd4096;
            rows[1] = 64'd4096 << 16;
            rows[2] = 64'd4096 << 32;
            rows[3] = 64'd4096 << 48;
            camera = 48'hC000_0000_0000;
            click = 48'hFFFF_0000_0000;
            mismatches = 0;
            clear_best();
        endfunction

        function void clear_best();
            have_best = 1'b0;
            best_dsq = EPS_SQ_Q28;
            best_mesh = '0;
            best_vertex = '0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [63:0] data);
            case (idx)
                CFG_ROW0:   rows[0] = data;
                CFG_ROW1:   rows[1] = data;
                CFG_ROW2:   rows[2] = data;
                CFG_ROW3:   rows[3] = data;
                CFG_CAMERA: camera = data[47:0];
                CFG_CLICK:  click = data[47:0];
                default:    ;
            endcase
        endfunction

        // Clip coordinate of one matrix row; the fourth entry scales 1.0.
        function longint clip_of(logic [63:0] row, longint px, longint py, longint pz);
            longint s;
            s = longint'($signed(row[15:0])) * px;
            s += longint'($signed(row[31:16])) * py;
            s += longint'($signed(row[47:32])) * pz;
            s += longint'($signed(row[63:48])) * 65536;
            return s;
        endfunction

        // Divide by w, truncating toward zero into saturated Q2.14.
        function longint ndc_of(longint c, longint w);
            longint unsigned mag, uw, q, r, f, m;
            mag = (c < 0) ? -c : c;
            uw = w;
            q = mag / uw;
            r = mag % uw;
            if (q >= 2) begin
                m = 65536;
            end else begin
                f = 0;
                for (int i = 0; i < 14; i++) begin
                    r = r << 1;
                    f = f << 1;
                    if (r >= uw) begin
                        r = r - uw;
                        f = f | 1;
                    end
                end
                m = (q << 14) | f;
            end
            if (c < 0) begin
                if (m > 32768) m = 32768;
                return -longint'(m);
            end
            if (m > 32767) m = 32767;
            return longint'(m);
        endfunction

        function void take_vertex(t_in_item v);
            longint px, py, pz, w, xn, yn, zn, dotp, dx, dy, dsq, depth;
            t_out_item pick;
            px = v.pos_x;
            py = v.pos_y;
            pz = v.pos_z;
            w = clip_of(rows[3], px, py, pz);
            if (w > 0) begin
                xn = ndc_of(clip_of(rows[0], px, py, pz), w);
                yn = ndc_of(clip_of(rows[1], px, py, pz), w);
                zn = ndc_of(clip_of(rows[2], px, py, pz), w);
                dotp = longint'($signed(camera[15:0])) * longint'(v.norm_x)
                     + longint'($signed(camera[31:16])) * longint'(v.norm_y)
                     + longint'($signed(camera[47:32])) * longint'(v.norm_z);
                dx = xn - longint'($signed(click[15:0]));
                dy = yn - longint'($signed(click[31:16]));
                dsq = dx * dx + dy * dy;
                if (dsq > 64'hFFFF_FFFF) dsq = 64'hFFFF_FFFF;
                depth = (zn + 16384) * 2;
                if (dotp <= -64'sd26843546 && dsq <= longint'(EPS_SQ_Q28) &&
                    dsq <= longint'(best_dsq) && depth <= longint'(click[47:32])) begin
                    have_best = 1'b1;
                    best_dsq = dsq[31:0];
                    best_mesh = v.mesh_id;
                    best_vertex = v.vertex_id;
                end
            end
            if (v.last_vertex) begin
                pick = '0;
                if (have_best) begin
                    pick.hit = 1'b1;
                    pick.hit_mesh = best_mesh;
                    pick.hit_vertex = best_vertex;
                    pick.hit_distance_sq = best_dsq;
                end
                pending_picks.insert(pending_picks.size(), pick);
                clear_best();
            end
        endfunction

        function void check_pick(t_out_item got);
            t_out_item want;
            if (pending_picks.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_picks.pop_front();
            if (got.hit !== want.hit) begin
                $display("%0t: hit expected %h actual %h", $time, want.hit, got.hit);
                mismatches++;
            end
            if (got.hit_mesh !== want.hit_mesh) begin
                $display("%0t: hit_mesh expected %h actual %h", $time,
                         want.hit_mesh, got.hit_mesh);
                mismatches++;
            end
            if (got.hit_vertex !== want.hit_vertex) begin
                $display("%0t: hit_vertex expected %h actual %h", $time,
                         want.hit_vertex, got.hit_vertex);
                mismatches++;
            end
            if (got.hit_distance_sq !== want.hit_distance_sq) begin
                $display("%0t: hit_distance_sq expected %h actual %h", $time,
                         want.hit_distance_sq, got.hit_distance_sq);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;

    pick_tracker tracker;

    // Steering for the two sides: a gap-free stretch for both sides and a
    // long hold-off for the receiver, which counts it down itself.
    bit     gapless;
    bit     hold_request;
    int     hold_left;

    // Diagonal scale of the current matrix and the click point, used to aim
    // well-formed vertices at the click so that picks actually happen.
    int          diag;
    logic [47:0] aim_camera;
    logic [47:0] aim_click;

    nearest_vertex_pick_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver: stalls at random about 17 percent of the time, or holds off for a long
    // stretch on request so the result register fills and the input backs up.
    initial begin
        i_out_stall = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !gapless && ($urandom_range(99) < 17);
            end
        end
    end

    // A result transfer happens at a rising edge with valid high and no stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_pick(o_out_data);
        end
    end

    // Generous overall limit; a correct run needs a small fraction of it.
    initial begin
        #20000000;
        $display("nearest_vertex_pick_top_tb: done, errors");
        $finish;
    end

    // One configuration write; the caller drops valid after its last write.
    task automatic write_reg(t_cfg_idx idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Sets a plain scaled-identity transform, with camera and click point.
    task automatic load_view(int d, logic [47:0] cam, logic [47:0] clk_pt);
        diag = d;
        aim_camera = cam;
        aim_click = clk_pt;
        write_reg(CFG_ROW0, 64'(d[15:0]));
        write_reg(CFG_ROW1, 64'(d[15:0]) << 16);
        write_reg(CFG_ROW2, 64'(d[15:0]) << 32);
        write_reg(CFG_ROW3, 64'd4096 << 48);
        write_reg(CFG_CAMERA, 64'(cam));
        write_reg(CFG_CLICK, 64'(clk_pt));
        i_cfg_valid <= 1'b0;
    endtask

    // Sends one vertex; called and left at a falling edge. Valid stays high
    // after the transfer so back-to-back vertices need no extra edge.
    task automatic send_vertex(t_in_item v);
        while (!gapless && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= v;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_vertex(v);
        @(negedge i_clk);
    endtask

    // Waits until every pick has come back, then lets one vertex time pass,
    // since a vertex that causes no result may still be in the pipeline.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.pending_picks.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    function automatic t_in_item make_vertex(logic [31:0] px, logic [31:0] py,
                                             logic [31:0] pz, logic [15:0] nz,
                                             logic [7:0] mesh, logic [23:0] vid,
                                             logic last);
        t_in_item v;
        v = '0;
        v.pos_x = px;
        v.pos_y = py;
        v.pos_z = pz;
        v.norm_z = nz;
        v.mesh_id = mesh;
        v.vertex_id = vid;
        v.last_vertex = last;
        return v;
    endfunction

    // A vertex aimed within about epsilon of the click, facing the camera,
    // with a random depth and random ids; the last flag is left clear.
    function automatic t_in_item aimed_vertex();
        t_in_item v;
        int tx, ty, tz;
        v = '0;
        tx = $signed(aim_click[15:0]) + $urandom_range(900) - 450;
        ty = $signed(aim_click[31:16]) + $urandom_range(900) - 450;
        tz = $urandom_range(32767) - 16384;
        v.pos_x = 32'((longint'(tx) * 16384) / diag);
        v.pos_y = 32'((longint'(ty) * 16384) / diag);
        v.pos_z = 32'((longint'(tz) * 16384) / diag);
        v.norm_x = -$signed(aim_camera[15:0]);
        v.norm_y = -$signed(aim_camera[31:16]);
        v.norm_z = -$signed(aim_camera[47:32]);
        v.mesh_id = 8'($urandom());
        v.vertex_id = 24'($urandom());
        return v;
    endfunction

    function automatic t_in_item noise_vertex();
        t_in_item v;
        v.pos_x = $urandom();
        v.pos_y = $urandom();
        v.pos_z = $urandom();
        v.norm_x = 16'($urandom());
        v.norm_y = 16'($urandom());
        v.norm_z = 16'($urandom());
        v.mesh_id = 8'($urandom());
        v.vertex_id = 24'($urandom());
        v.last_vertex = 1'($urandom());
        return v;
    endfunction

    // A random view whose camera is long enough that aimed normals face it.
    task automatic random_view();
        logic [15:0] cx, cy, cz, kx, ky, dbv;
        int ds [3] = '{4096, 8192, 2048};
        cx = 16'($urandom_range(16000) - 8000);
        cy = 16'($urandom_range(16000) - 8000);
        cz = 16'(-$urandom_range(16384, 8000));
        kx = 16'($urandom_range(24000) - 12000);
        ky = 16'($urandom_range(24000) - 12000);
        dbv = $urandom_range(1) ? 16'hFFFF : 16'($urandom());
        load_view(ds[$urandom_range(2)], {cz, cy, cx}, {dbv, ky, kx});
    endtask

    // Scenes of random length, aimed or noise vertices in the given mix, each closed by a
    // last-flagged vertex so that the phase ends with nothing in flight.
    task automatic run_scenes(int count, int max_len, int noise_pct);
        t_in_item v;
        int len;
        while (count > 0) begin
            len = $urandom_range(max_len, 1);
            for (int k = 0; k < len; k++) begin
                v = ($urandom_range(99) < noise_pct) ? noise_vertex() : aimed_vertex();
                v.last_vertex = (k == len - 1);
                send_vertex(v);
            end
            count -= len;
        end
    endtask

    initial begin
        tracker = new();
        gapless = 1'b0;
        hold_request = 1'b0;
        diag = 4096;
        aim_camera = 48'hC000_0000_0000;
        aim_click = 48'hFFFF_0000_0000;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ROW0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset view: identity, click at the center,
        // camera looking down -z, so NDC is a quarter of the Q16.16 position.
        send_vertex(make_vertex(0, 0, 0, 16'sd16384, 8'd1, 24'd1, 1'b0));
        // Equal distance: the later vertex wins the tie.
        send_vertex(make_vertex(0, 0, 0, 16'sd16384, 8'd2, 24'd2, 1'b0));
        // Facing away from the camera.
        send_vertex(make_vertex(0, 0, 0, -16'sd16384, 8'd3, 24'd3, 1'b0));
        send_vertex(make_vertex(32'h7FFF_FFFF, 0, 0, 16'sd16384, 8'd4, 24'd4, 1'b1));
        // Extremes of every field, and normals outside the unit range.
        begin
            t_in_item v;
            v.pos_x = 32'h8000_0000; v.pos_y = 32'h8000_0000; v.pos_z = 32'h8000_0000;
            v.norm_x = 16'h8000; v.norm_y = 16'h8000; v.norm_z = 16'h8000;
            v.mesh_id = 8'hFF; v.vertex_id = 24'hFF_FFFF; v.last_vertex = 1'b1;
            send_vertex(v);
            v.pos_x = 32'h7FFF_FFFF; v.pos_y = 32'h7FFF_FFFF; v.pos_z = 32'h7FFF_FFFF;
            v.norm_x = 16'h7FFF; v.norm_y = 16'h7FFF; v.norm_z = 16'h7FFF;
            send_vertex(v);
        end
        // Closer vertices replace the best, a farther one does not.
        send_vertex(make_vertex(4 * 300, 0, 0, 16'sd16384, 8'd5, 24'd5, 1'b0));
        send_vertex(make_vertex(4 * 200, 0, 0, 16'sd16384, 8'd6, 24'd6, 1'b0));
        send_vertex(make_vertex(4 * 250, 0, 0, 16'sd16384, 8'd7, 24'd7, 1'b0));
        send_vertex(make_vertex(0, 0, 0, -16'sd100, 8'd8, 24'd8, 1'b1));
        // Just inside and just outside epsilon.
        send_vertex(make_vertex(4 * 409, 0, 0, 16'sd16384, 8'd9, 24'd9, 1'b1));
        send_vertex(make_vertex(4 * 410, 0, 0, 16'sd16384, 8'd10, 24'd10, 1'b1));
        // Either side of the facing threshold.
        send_vertex(make_vertex(0, 0, 0, 16'd1639, 8'd11, 24'd11, 1'b1));
        send_vertex(make_vertex(0, 0, 0, 16'd1638, 8'd12, 24'd12, 1'b1));
        drain();

        // Depth buffer at a quarter: visible only when z NDC is at most -0.5.
        load_view(4096, 48'hC000_0000_0000, 48'h4000_0000_0000);
        send_vertex(make_vertex(0, 0, -32'sd32768, 16'sd16384, 8'd13, 24'd13, 1'b1));
        send_vertex(make_vertex(0, 0, -32'sd32764, 16'sd16384, 8'd14, 24'd14, 1'b1));
        drain();

        // w taken from z: zero and negative w are misses.
        write_reg(CFG_ROW3, 64'd4096 << 32);
        write_reg(CFG_CLICK, 64'hFFFF_0000_0000);
        i_cfg_valid <= 1'b0;
        send_vertex(make_vertex(0, 0, 0, 16'sd16384, 8'd15, 24'd15, 1'b1));
        send_vertex(make_vertex(0, 0, -32'sd65536, 16'sd16384, 8'd16, 24'd16, 1'b1));
        send_vertex(make_vertex(0, 0, 32'sd65536, 16'sd16384, 8'd17, 24'd17, 1'b1));
        send_vertex(make_vertex(32'sd100, 0, 32'sd65536, 16'sd16384, 8'd18, 24'd18, 1'b1));
        drain();

        // Register extremes: all ones, then all zeros (w is zero everywhere).
        for (int r = 0; r < 6; r++) write_reg(t_cfg_idx'(r), '1);
        i_cfg_valid <= 1'b0;
        run_scenes(30, 4, 100);
        drain();
        for (int r = 0; r < 6; r++) write_reg(t_cfg_idx'(r), '0);
        i_cfg_valid <= 1'b0;
        run_scenes(20, 4, 100);
        drain();

        // Random phases, mostly well-formed scenes aimed at the click.
        for (int ph = 0; ph < 8; ph++) begin
            random_view();
            gapless = (ph == 2);
            if (ph == 4) begin
                // Short scenes under a long hold-off, so results back up.
                hold_request = 1'b1;
                run_scenes(40, 2, 15);
            end
            run_scenes(90, 10, 20);
            gapless = 1'b0;
            drain();
        end

        // Fully random transforms: picks are rare but prediction still holds.
        for (int r = 0; r < 6; r++) write_reg(t_cfg_idx'(r), {$urandom(), $urandom()});
        i_cfg_valid <= 1'b0;
        run_scenes(60, 6, 100);
        drain();

        // Back to a plain view; the drain above already waited out the tail.
        load_view(4096, 48'hC000_0000_0000, 48'hFFFF_0000_0000);
        run_scenes(30, 5, 10);
        drain();

        if (tracker.mismatches == 0 && tracker.pending_picks.size() == 0) begin
            $display("nearest_vertex_pick_top_tb: done, clean");
        end else begin
            $display("nearest_vertex_pick_top_tb: done, errors");
        end
        $finish;
    end

endmodule
